// File: design/dlgc_pkg.sv
// ----------------------------------------------------------------------------
// dlgc_pkg
// Shared types and constants for the dual shift register gold code generator.
// ----------------------------------------------------------------------------
package dlgc_pkg;

  localparam int MAX_STAGES = 32;
  localparam int INDEX_BITS = 20;
  localparam int STAGE_IDX_W = $clog2(MAX_STAGES);
  localparam int CFG_DATA_W = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int LEN_W = 6;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = ((1 + INDEX_BITS + 7) / 8) * 8;

  localparam logic [31:0] G1_INIT_RST = 32'h0000_00df;
  localparam logic [31:0] G1_TAPS_RST = 32'h0000_03a6;
  localparam logic [31:0] G2_INIT_RST = 32'h0000_03ff;
  localparam logic [31:0] G2_TAPS_RST = 32'h0000_0204;
  localparam logic [LEN_W-1:0] REG_LENGTH_RST = LEN_W'(10);
  localparam logic [INDEX_BITS-1:0] CODE_LENGTH_RST = INDEX_BITS'(1023);
  localparam logic [INDEX_BITS-1:0] G2_RELOAD_AT_RST = INDEX_BITS'(1023);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_G1_INIT      = 3'd0,
    REG_G1_TAPS      = 3'd1,
    REG_G2_INIT      = 3'd2,
    REG_G2_TAPS      = 3'd3,
    REG_REG_LENGTH   = 3'd4,
    REG_CODE_LENGTH  = 3'd5,
    REG_G2_RELOAD_AT = 3'd6
  } cfg_reg_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [MAX_STAGES-1:0]  g1_init;
    logic [MAX_STAGES-1:0]  g1_taps;
    logic [MAX_STAGES-1:0]  g2_init;
    logic [MAX_STAGES-1:0]  g2_taps;
    logic [MAX_STAGES-1:0]  stage_mask;
    logic [STAGE_IDX_W-1:0] out_pos;
    logic [INDEX_BITS-1:0]  last_index;
    logic [INDEX_BITS-1:0]  g2_reload_at;
  } cfg_t;

  // per-chip control for one shift register
  typedef struct packed {
    logic fire;
    logic preload;
    logic wrap;
  } lfsr_ctl_t;

endpackage

// File: design/dlgc_cfg.sv
// ----------------------------------------------------------------------------
// dlgc_cfg
// Configuration register file and derived stage mask / period limits.
// ----------------------------------------------------------------------------
module dlgc_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dlgc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dlgc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output dlgc_pkg::cfg_t                    cfg
);

  logic [31:0]                      g1_init_r;
  logic [31:0]                      g1_taps_r;
  logic [31:0]                      g2_init_r;
  logic [31:0]                      g2_taps_r;
  logic [dlgc_pkg::LEN_W-1:0]       reg_length_r;
  logic [dlgc_pkg::INDEX_BITS-1:0]  code_length_r;
  logic [dlgc_pkg::INDEX_BITS-1:0]  g2_reload_at_r;
  logic [dlgc_pkg::LEN_W:0]         stages;
  logic                             wr;

  assign cfg_ready = 1'b1;
  assign wr = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_init_r      <= dlgc_pkg::G1_INIT_RST;
      g1_taps_r      <= dlgc_pkg::G1_TAPS_RST;
      g2_init_r      <= dlgc_pkg::G2_INIT_RST;
      g2_taps_r      <= dlgc_pkg::G2_TAPS_RST;
      reg_length_r   <= dlgc_pkg::REG_LENGTH_RST;
      code_length_r  <= dlgc_pkg::CODE_LENGTH_RST;
      g2_reload_at_r <= dlgc_pkg::G2_RELOAD_AT_RST;
    end else if (wr) begin
      case (dlgc_pkg::cfg_reg_t'(cfg_index))
        dlgc_pkg::REG_G1_INIT:      g1_init_r      <= cfg_data;
        dlgc_pkg::REG_G1_TAPS:      g1_taps_r      <= cfg_data;
        dlgc_pkg::REG_G2_INIT:      g2_init_r      <= cfg_data;
        dlgc_pkg::REG_G2_TAPS:      g2_taps_r      <= cfg_data;
        dlgc_pkg::REG_REG_LENGTH:   reg_length_r   <= cfg_data[dlgc_pkg::LEN_W-1:0];
        dlgc_pkg::REG_CODE_LENGTH:  code_length_r  <= cfg_data[dlgc_pkg::INDEX_BITS-1:0];
        dlgc_pkg::REG_G2_RELOAD_AT: g2_reload_at_r <= cfg_data[dlgc_pkg::INDEX_BITS-1:0];
        default: ;
      endcase
    end
  end

  // stage count clamped to 1..MAX_STAGES
  always_comb begin
    if (reg_length_r == '0) begin
      stages = (dlgc_pkg::LEN_W+1)'(1);
    end else if ({1'b0, reg_length_r} > (dlgc_pkg::LEN_W+1)'(dlgc_pkg::MAX_STAGES)) begin
      stages = (dlgc_pkg::LEN_W+1)'(dlgc_pkg::MAX_STAGES);
    end else begin
      stages = {1'b0, reg_length_r};
    end
  end

  always_comb begin
    for (int i = 0; i < dlgc_pkg::MAX_STAGES; i++) begin
      cfg.stage_mask[i] = ((dlgc_pkg::LEN_W+1)'(i) < stages);
    end
    cfg.out_pos      = dlgc_pkg::STAGE_IDX_W'(stages - (dlgc_pkg::LEN_W+1)'(1));
    cfg.g1_init      = dlgc_pkg::MAX_STAGES'(g1_init_r);
    cfg.g1_taps      = dlgc_pkg::MAX_STAGES'(g1_taps_r);
    cfg.g2_init      = dlgc_pkg::MAX_STAGES'(g2_init_r);
    cfg.g2_taps      = dlgc_pkg::MAX_STAGES'(g2_taps_r);
    // zero length acts as one chip per period
    cfg.last_index   = (code_length_r == '0) ? '0
                     : code_length_r - dlgc_pkg::INDEX_BITS'(1);
    cfg.g2_reload_at = g2_reload_at_r;
  end

endmodule

// File: design/dlgc_lfsr.sv
// ----------------------------------------------------------------------------
// dlgc_lfsr
// One Fibonacci shift register: output tap, parity feedback and reload.
// ----------------------------------------------------------------------------
module dlgc_lfsr (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [dlgc_pkg::MAX_STAGES-1:0]     rst_state,
  input  logic [dlgc_pkg::MAX_STAGES-1:0]     init,
  input  logic [dlgc_pkg::MAX_STAGES-1:0]     taps,
  input  logic [dlgc_pkg::MAX_STAGES-1:0]     stage_mask,
  input  logic [dlgc_pkg::STAGE_IDX_W-1:0]    out_pos,
  input  dlgc_pkg::lfsr_ctl_t                 ctl,
  output logic                                out_bit
);

  logic [dlgc_pkg::MAX_STAGES-1:0] state_r;
  logic [dlgc_pkg::MAX_STAGES-1:0] state_nxt;
  logic [dlgc_pkg::MAX_STAGES-1:0] init_m;
  logic [dlgc_pkg::MAX_STAGES-1:0] cur;
  logic [dlgc_pkg::MAX_STAGES-1:0] adv;
  logic                            fb;

  assign init_m  = init & stage_mask;
  assign cur     = ctl.preload ? init_m : state_r;
  assign out_bit = cur[out_pos];
  assign fb      = ^(cur & taps);
  assign adv     = {cur[dlgc_pkg::MAX_STAGES-2:0], fb} & stage_mask;

  always_comb begin
    state_nxt = state_r;
    if (ctl.fire) begin
      state_nxt = ctl.wrap ? init_m : adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rst_state;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/dual_lfsr_gold_code_generator.sv
// ----------------------------------------------------------------------------
// dual_lfsr_gold_code_generator
// Gold code chip generator built from two configurable shift registers.
//
//   channel  direction  handshake            payload
//   in_      slave      in_tvalid/in_tready  in_tdata[0] restart
//   out_     master     out_tvalid/tready    out_tdata chip, chip_index; tlast
//   cfg_     slave      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one chip per clock while out_ is not stalled; a word waits in the input
// register, then passes to the output register. the chip logic between the
// two registers is a masked shift, a parity tree and a 20-bit compare.
// synchronous reset loads the reset configuration and the initial states.
// a stalled output holds the input stage as well; cfg_ready is always high.
// ----------------------------------------------------------------------------
module dual_lfsr_gold_code_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [dlgc_pkg::IN_TDATA_W-1:0]     in_tdata,   // [0] restart
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dlgc_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [0] chip, [20:1] chip_index
  output logic                                out_tlast,  // last_of_period
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dlgc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dlgc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  dlgc_pkg::cfg_t       cfg;
  dlgc_pkg::lfsr_ctl_t  g1_ctl;
  dlgc_pkg::lfsr_ctl_t  g2_ctl;

  logic                             in_valid_r;
  logic                             restart_r;
  logic                             out_valid_r;
  logic                             out_valid_nxt;
  logic                             chip_r;
  logic [dlgc_pkg::INDEX_BITS-1:0]  index_r;
  logic                             last_r;
  logic [dlgc_pkg::INDEX_BITS-1:0]  cnt_r;
  logic [dlgc_pkg::INDEX_BITS-1:0]  cnt_nxt;
  logic [dlgc_pkg::INDEX_BITS-1:0]  idx;
  logic                             advance;
  logic                             fire;
  logic                             last;
  logic                             g1_bit;
  logic                             g2_bit;

  dlgc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  assign idx  = restart_r ? '0 : cnt_r;
  assign last = (idx >= cfg.last_index);

  always_comb begin
    g1_ctl.fire    = fire;
    g1_ctl.preload = restart_r;
    g1_ctl.wrap    = last;
    g2_ctl.fire    = fire;
    // mid-period reload of the second register
    g2_ctl.preload = restart_r || (idx == cfg.g2_reload_at);
    g2_ctl.wrap    = last;
  end

  dlgc_lfsr u_g1 (
    .clk        (clk),
    .rst_n      (rst_n),
    .rst_state  (dlgc_pkg::MAX_STAGES'(dlgc_pkg::G1_INIT_RST)),
    .init       (cfg.g1_init),
    .taps       (cfg.g1_taps),
    .stage_mask (cfg.stage_mask),
    .out_pos    (cfg.out_pos),
    .ctl        (g1_ctl),
    .out_bit    (g1_bit)
  );

  dlgc_lfsr u_g2 (
    .clk        (clk),
    .rst_n      (rst_n),
    .rst_state  (dlgc_pkg::MAX_STAGES'(dlgc_pkg::G2_INIT_RST)),
    .init       (cfg.g2_init),
    .taps       (cfg.g2_taps),
    .stage_mask (cfg.stage_mask),
    .out_pos    (cfg.out_pos),
    .ctl        (g2_ctl),
    .out_bit    (g2_bit)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (fire) begin
      cnt_nxt = last ? '0 : idx + dlgc_pkg::INDEX_BITS'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      restart_r <= in_tdata[0];
    end
    if (fire) begin
      chip_r  <= g1_bit ^ g2_bit;
      index_r <= idx;
      last_r  <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = dlgc_pkg::OUT_TDATA_W'({index_r, chip_r});
  assign out_tlast  = last_r;

endmodule

// File: bench/tb_dual_lfsr_gold_code_generator.sv
// ----------------------------------------------------------------------------
// tb_dual_lfsr_gold_code_generator
// Self-checking bench for the two-register gold code chip generator.
//
// A short scripted sequence steps through reset defaults, register extremes
// and restarts. Many randomly configured code setups follow. An internal chip
// predictor tracks both shift registers and the chip index. Every output word
// is checked field by field against it or a scripted expectation. Both stream
// sides idle at random. One long output stall backs the block up.
// ----------------------------------------------------------------------------
module tb_dual_lfsr_gold_code_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import dlgc_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned SETTLE = 4;
  localparam int unsigned LONG_HOLD = 200;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RAND_SETUPS = 12;
  localparam int unsigned CHIPS_PER_SETUP = 125;
  localparam int unsigned HOLD_SETUP = 3;
  localparam int unsigned PAUSE_SETUP = 6;

  typedef struct packed {
    logic                  chip;
    logic [INDEX_BITS-1:0] idx;
    logic                  last;
  } chip_t;

  typedef enum logic {ROW_CHIP, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic                   restart;
    logic                   typed;
    chip_t                  want;
    logic [CFG_INDEX_W-1:0] sel;
    logic [CFG_DATA_W-1:0]  value;
  } row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [0] restart
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [0] chip, [20:1] chip_index
  logic                   out_tlast;  // last_of_period
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  dual_lfsr_gold_code_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of configuration and code state
  logic [31:0]           g1_init_q, g1_taps_q, g2_init_q, g2_taps_q;
  logic [LEN_W-1:0]      reg_length_q;
  logic [INDEX_BITS-1:0] code_len_q, g2_reload_q;
  logic [31:0]           g1_state, g2_state;
  logic [INDEX_BITS-1:0] period_pos;

  chip_t       pending_chips[$];
  row_t        plan[$];
  int unsigned fail_count, items_sent, restarts_sent, chips_seen, periods_seen;
  int unsigned writes_done, setups_run;
  int unsigned holds_asked, holds_done;

  function automatic int unsigned tap_len();
    int unsigned n;
    n = 32'(reg_length_q);
    if (n < 1) n = 1;
    if (n > MAX_STAGES) n = MAX_STAGES;
    return n;
  endfunction

  function automatic logic [31:0] len_mask();
    logic [32:0] m;
    m = (33'd1 << tap_len()) - 33'd1;
    return m[31:0];
  endfunction

  function automatic logic [31:0] lfsr_next(logic [31:0] st, logic [31:0] taps);
    return ((st << 1) | 32'(^(st & taps))) & len_mask();
  endfunction

  function automatic void reload_codes();
    g1_state = g1_init_q & len_mask();
    g2_state = g2_init_q & len_mask();
    period_pos = '0;
  endfunction

  function automatic void defaults_after_reset();
    g1_init_q = G1_INIT_RST;
    g1_taps_q = G1_TAPS_RST;
    g2_init_q = G2_INIT_RST;
    g2_taps_q = G2_TAPS_RST;
    reg_length_q = REG_LENGTH_RST;
    code_len_q = CODE_LENGTH_RST;
    g2_reload_q = G2_RELOAD_AT_RST;
    reload_codes();
  endfunction

  function automatic void apply_write(logic [CFG_INDEX_W-1:0] sel, logic [31:0] v);
    case (sel)
      REG_G1_INIT:      g1_init_q = v;
      REG_G1_TAPS:      g1_taps_q = v;
      REG_G2_INIT:      g2_init_q = v;
      REG_G2_TAPS:      g2_taps_q = v;
      REG_REG_LENGTH:   reg_length_q = v[LEN_W-1:0];
      REG_CODE_LENGTH:  code_len_q = v[INDEX_BITS-1:0];
      REG_G2_RELOAD_AT: g2_reload_q = v[INDEX_BITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic chip_t next_chip(logic restart);
    chip_t                 c;
    int unsigned           n;
    logic [INDEX_BITS-1:0] pos;
    logic [INDEX_BITS:0]   span;
    if (restart) reload_codes();
    n = tap_len();
    pos = period_pos;
    if (pos == g2_reload_q) g2_state = g2_init_q & len_mask();
    c.chip = g1_state[n-1] ^ g2_state[n-1];
    g1_state = lfsr_next(g1_state, g1_taps_q);
    g2_state = lfsr_next(g2_state, g2_taps_q);
    // a zero length behaves as a one-chip period
    span = (code_len_q == '0) ? (INDEX_BITS+1)'(1) : {1'b0, code_len_q};
    c.idx = pos;
    c.last = ({1'b0, pos} + (INDEX_BITS+1)'(1)) >= span;
    if (c.last) reload_codes();
    else period_pos = pos + 1'b1;
    return c;
  endfunction

  function automatic int unsigned pick_gap(logic calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic void add_chip(logic restart);
    row_t r;
    r = '0;
    r.kind = ROW_CHIP;
    r.restart = restart;
    plan.push_back(r);
  endfunction

  function automatic void add_typed(logic restart, logic ch, int unsigned idx, logic last);
    row_t r;
    r = '0;
    r.kind = ROW_CHIP;
    r.restart = restart;
    r.typed = 1'b1;
    r.want.chip = ch;
    r.want.idx = idx[INDEX_BITS-1:0];
    r.want.last = last;
    plan.push_back(r);
  endfunction

  function automatic void add_write(logic [CFG_INDEX_W-1:0] sel, logic [31:0] v);
    row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.sel = sel;
    r.value = v;
    plan.push_back(r);
  endfunction

  task automatic send_word(logic restart, logic typed, chip_t want, int unsigned gap);
    chip_t predicted;
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'(restart);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = next_chip(restart);
    pending_chips.push_back(typed ? want : predicted);
    items_sent++;
    if (restart) restarts_sent++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering words and let every outstanding chip come out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_chips.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] sel, logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_write(sel, v);
    writes_done++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_setup(logic every);
    logic [LEN_W-1:0]      len;
    logic [INDEX_BITS-1:0] span;
    logic [INDEX_BITS-1:0] reload;
    int unsigned           r;
    if (every || $urandom_range(0, 4) != 0) write_reg(REG_G1_INIT, $urandom());
    if (every || $urandom_range(0, 4) != 0) write_reg(REG_G1_TAPS, $urandom());
    if (every || $urandom_range(0, 4) != 0) write_reg(REG_G2_INIT, $urandom());
    if (every || $urandom_range(0, 4) != 0) write_reg(REG_G2_TAPS, $urandom());
    // out-of-range lengths now and then, mostly ordinary ones
    case ($urandom_range(0, 19))
      0:       len = LEN_W'(0);
      1:       len = LEN_W'(1);
      2:       len = LEN_W'(32);
      3:       len = LEN_W'(33);
      4:       len = LEN_W'(63);
      default: len = LEN_W'($urandom_range(2, 31));
    endcase
    if (every || $urandom_range(0, 4) != 0) write_reg(REG_REG_LENGTH, CFG_DATA_W'(len));
    r = $urandom_range(0, 19);
    if (r == 0) span = '0;
    else if (r == 1) span = '1;
    else if (r < 14) span = INDEX_BITS'($urandom_range(1, 40));
    else span = INDEX_BITS'($urandom_range(41, 1100));
    if (every || $urandom_range(0, 4) != 0) write_reg(REG_CODE_LENGTH, CFG_DATA_W'(span));
    if ($urandom_range(0, 6) == 0)
      reload = INDEX_BITS'($urandom_range(0, (1 << INDEX_BITS) - 1));
    else
      reload = INDEX_BITS'($urandom_range(0, code_len_q));
    if (every || $urandom_range(0, 4) != 0) write_reg(REG_G2_RELOAD_AT, CFG_DATA_W'(reload));
  endtask

  task automatic flag_field(string what, longint unsigned exp_v, longint unsigned act_v);
    fail_count++;
    $display("%0t %s mismatch: expected %0d, got %0d", $time, what, exp_v, act_v);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result checker
  always @(posedge clk) begin : check_chips
    chip_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.chip = out_tdata[0];
      got.idx = out_tdata[INDEX_BITS:1];
      got.last = out_tlast;
      chips_seen++;
      if (got.last) periods_seen++;
      if (pending_chips.size() == 0) begin
        flag_field("unrequested word, chip_index", 0, got.idx);
      end else begin
        want = pending_chips.pop_front();
        if (got.chip !== want.chip) flag_field("chip", want.chip, got.chip);
        if (got.idx !== want.idx) flag_field("chip_index", want.idx, got.idx);
        if (got.last !== want.last) flag_field("last_of_period", want.last, got.last);
      end
    end
  end

  initial begin : receiver
    int unsigned stall_left, calm_left;
    stall_left = 0;
    calm_left = 0;
    holds_done = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (holds_done != holds_asked) begin
        // long back-pressure while the sender keeps offering words
        holds_done = holds_asked;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
        @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
        if (calm_left != 0) calm_left--;
        else if ($urandom_range(0, 299) == 0) calm_left = $urandom_range(50, 200);
        else if ($urandom_range(0, 3) == 0) stall_left = pick_gap(1'b0);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    logic        calm;
    int unsigned restart_pct;
    fail_count = 0;
    items_sent = 0;
    restarts_sent = 0;
    chips_seen = 0;
    periods_seen = 0;
    writes_done = 0;
    setups_run = 0;
    holds_asked = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_G1_INIT;
    cfg_data <= '0;
    defaults_after_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: first chips and a restart
    add_typed(1'b0, 1'b1, 0, 1'b0);
    add_typed(1'b0, 1'b1, 1, 1'b0);
    add_typed(1'b0, 1'b0, 2, 1'b0);
    add_typed(1'b1, 1'b1, 0, 1'b0);
    add_chip(1'b0);
    add_chip(1'b0);
    // zero code length, index already past the end of the period
    add_write(REG_CODE_LENGTH, 32'd0);
    add_chip(1'b0);
    add_chip(1'b0);
    add_chip(1'b1);
    // one-stage registers from a zero length, all-ones init and taps
    add_write(REG_CODE_LENGTH, 32'd3);
    add_write(REG_REG_LENGTH, 32'd0);
    add_write(REG_G1_INIT, 32'hffff_ffff);
    add_write(REG_G1_TAPS, 32'hffff_ffff);
    add_chip(1'b1);
    add_chip(1'b0);
    add_chip(1'b0);
    add_chip(1'b0);
    // oversized length clamps to 32 stages; second register stuck at zero
    add_write(REG_REG_LENGTH, 32'd63);
    add_write(REG_G2_INIT, 32'd0);
    add_write(REG_G2_TAPS, 32'hffff_ffff);
    add_write(REG_G2_RELOAD_AT, 32'd1);
    add_write(REG_CODE_LENGTH, 32'd6);
    add_typed(1'b1, 1'b1, 0, 1'b0);
    add_typed(1'b0, 1'b1, 1, 1'b0);
    add_typed(1'b0, 1'b1, 2, 1'b0);
    add_typed(1'b0, 1'b1, 3, 1'b0);
    add_typed(1'b0, 1'b1, 4, 1'b0);
    add_typed(1'b0, 1'b1, 5, 1'b1);
    // both registers all zero, longest period; unmapped index must not land
    add_write(REG_REG_LENGTH, 32'd32);
    add_write(REG_G1_INIT, 32'd0);
    add_write(REG_G1_TAPS, 32'd0);
    add_write(REG_G2_RELOAD_AT, 32'd0);
    add_write(REG_CODE_LENGTH, 32'h000f_ffff);
    add_write(REG_UNUSED, 32'd1);
    add_typed(1'b1, 1'b0, 0, 1'b0);
    add_typed(1'b0, 1'b0, 1, 1'b0);
    add_typed(1'b0, 1'b0, 2, 1'b0);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_WRITE: begin
          drain();
          write_reg(plan[i].sel, plan[i].value);
        end
        default: begin
          send_word(plan[i].restart, plan[i].typed, plan[i].want, pick_gap(1'b0));
        end
      endcase
    end

    // thirteen-stage code with a period longer than the run of words
    drain();
    write_reg(REG_REG_LENGTH, 32'd13);
    write_reg(REG_G1_INIT, 32'h0000_1fff);
    write_reg(REG_G1_TAPS, 32'h0000_18ed);
    write_reg(REG_G2_INIT, $urandom());
    write_reg(REG_G2_TAPS, 32'h0000_1b00);
    write_reg(REG_CODE_LENGTH, 32'd8190);
    write_reg(REG_G2_RELOAD_AT, 32'd8190);
    setups_run++;
    for (int k = 0; k < 300; k++)
      send_word($urandom_range(0, 99) == 0, 1'b0, '0, pick_gap(1'b0));

    for (int p = 0; p < RAND_SETUPS; p++) begin
      drain();
      random_setup(p == 0);
      setups_run++;
      calm = (p == HOLD_SETUP) || ($urandom_range(0, 4) == 0);
      if (p == HOLD_SETUP) holds_asked++;
      restart_pct = $urandom_range(0, 8);
      for (int k = 0; k < CHIPS_PER_SETUP; k++) begin
        if (p == PAUSE_SETUP && k == CHIPS_PER_SETUP / 2) drain();
        send_word($urandom_range(0, 99) < restart_pct, 1'b0, '0, pick_gap(calm));
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("%0d words sent (%0d restarts), %0d chips checked, %0d period ends",
             items_sent, restarts_sent, chips_seen, periods_seen);
    $display("%0d register writes over %0d code setups", writes_done, setups_run);
    if (fail_count == 0 && pending_chips.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
